/* rtl/msot_pkg.sv */
`timescale 1ns / 1ps

package msot_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int ID_W          = 4;
    localparam int SEL_SPAN      = 2 ** ID_W;
    localparam int FIRE_CNT_W    = 5;
    localparam logic [FIRE_CNT_W-1:0] MAX_FIRES = 5'd16;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_ARM_ONE  = 2'd1,
        FUNC_ARM_PER  = 2'd2,
        FUNC_CANCEL   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ARMED    = 2'd0,
        KIND_REFUSED  = 2'd1,
        KIND_CANCELED = 2'd2,
        KIND_FIRED    = 2'd3
    } kind_t;

    typedef struct packed {
        func_t             func;
        logic [23:0]       delay_ms;
        logic [ID_W-1:0]   slot_sel;
    } in_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   slot_id;
        logic              was_active;
        logic              last;
    } out_t;

    typedef struct packed {
        logic                  valid;
        func_t                 func;
        logic [23:0]           delay;
        logic [ID_W-1:0]       sel;
        logic [31:0]           now;
        logic                  found;
        logic [ID_W-1:0]       slot;
        logic                  was;
        logic [FIRE_CNT_W-1:0] fire_cnt;
    } tok_t;

    typedef struct packed {
        logic            req;
        logic [ID_W-1:0] slot;
    } fire_t;

endpackage

/* rtl/multi_slot_oneshot_periodic_timer.sv */
`timescale 1ns / 1ps
// Array of NUM_SLOTS one-shot / periodic timer slots.
// Input channel s_valid/s_ready/s_data carries one operation per transfer:
// tick (advance the millisecond count), arm one-shot, arm periodic, cancel.
// Result channel m_valid/m_ready/m_data carries armed, refused, cancel-ack
// and fired results; last marks the final result of an operation. A tick
// with nothing due gives no result.
// Each operation travels as a token through a row of NUM_SLOTS cells, one
// cell per cycle while the output does not stall, each cell holding one
// slot. The final result of an operation appears at the same edge at which
// s_ready rises again.
// One operation is in flight at a time. Fired results are staged one behind
// so that last can be set on the final one.
// When the receiver holds m_ready low, the token freezes at the cell that
// needs the output, and the operation stretches by the stall time.
// Synchronous reset clears the millisecond count and frees every slot.
module multi_slot_oneshot_periodic_timer #(
    parameter int NUM_SLOTS = msot_pkg::NUM_SLOTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  msot_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output msot_pkg::out_t m_data
);
    import msot_pkg::*;

    tok_t  chain [NUM_SLOTS+1];
    fire_t fires [NUM_SLOTS];

    logic            busy_reg;
    logic            busy_next;
    logic [31:0]     now_reg;
    logic [31:0]     now_next;
    tok_t            tok0_reg;
    tok_t            tok0_next;
    logic            hold_valid_reg;
    logic            hold_valid_next;
    logic [ID_W-1:0] hold_slot_reg;
    logic [ID_W-1:0] hold_slot_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    out_t            m_data_reg;
    out_t            m_data_next;

    logic            accept;
    logic            out_free;
    logic            fire_any;
    logic [ID_W-1:0] fire_slot;
    tok_t            end_tok;
    logic            end_needs_out;
    logic            stall;
    logic            load_out;
    logic [NUM_SLOTS:0] tok_vld;

    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign chain[0] = tok0_reg;
    assign end_tok  = chain[NUM_SLOTS];

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            msot_cell #(
                .IDX(g)
            ) u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .stall  (stall),
                .tok_in (chain[g]),
                .tok_out(chain[g+1]),
                .fire   (fires[g])
            );
        end
    endgenerate

    always_comb begin
        fire_any  = 1'b0;
        fire_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            fire_any = fire_any | fires[i].req;
            if (fires[i].req) begin
                fire_slot = fire_slot | fires[i].slot;
            end
        end
    end

    always_comb begin
        for (int i = 0; i <= NUM_SLOTS; i++) begin
            tok_vld[i] = chain[i].valid;
        end
    end

    assign end_needs_out = end_tok.valid && ((end_tok.func != FUNC_TICK) || hold_valid_reg);
    assign stall = !out_free && ((fire_any && hold_valid_reg) || end_needs_out);

    always_comb begin
        load_out    = 1'b0;
        m_data_next = m_data_reg;
        if (fire_any && hold_valid_reg && !stall) begin
            load_out    = 1'b1;
            m_data_next = '{kind: KIND_FIRED, slot_id: hold_slot_reg,
                            was_active: 1'b0, last: 1'b0};
        end else if (end_tok.valid && !stall) begin
            case (end_tok.func)
                FUNC_TICK: begin
                    if (hold_valid_reg) begin
                        load_out    = 1'b1;
                        m_data_next = '{kind: KIND_FIRED, slot_id: hold_slot_reg,
                                        was_active: 1'b0, last: 1'b1};
                    end
                end
                FUNC_ARM_ONE, FUNC_ARM_PER: begin
                    load_out = 1'b1;
                    if (end_tok.found) begin
                        m_data_next = '{kind: KIND_ARMED, slot_id: end_tok.slot,
                                        was_active: 1'b0, last: 1'b1};
                    end else begin
                        m_data_next = '{kind: KIND_REFUSED, slot_id: '0,
                                        was_active: 1'b0, last: 1'b1};
                    end
                end
                FUNC_CANCEL: begin
                    load_out    = 1'b1;
                    m_data_next = '{kind: KIND_CANCELED, slot_id: end_tok.sel,
                                    was_active: end_tok.was, last: 1'b1};
                end
                default: begin
                    load_out = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next    = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        busy_next       = busy_reg;
        now_next        = now_reg;
        tok0_next       = tok0_reg;

        if (fire_any && !stall) begin
            hold_valid_next = 1'b1;
            hold_slot_next  = fire_slot;
        end else if (end_tok.valid && !stall && (end_tok.func == FUNC_TICK)) begin
            hold_valid_next = 1'b0;
        end

        if (end_tok.valid && !stall) begin
            busy_next = 1'b0;
        end

        if (accept) begin
            busy_next          = 1'b1;
            tok0_next.valid    = 1'b1;
            tok0_next.func     = s_data.func;
            tok0_next.delay    = s_data.delay_ms;
            tok0_next.sel      = s_data.slot_sel;
            tok0_next.now      = (s_data.func == FUNC_TICK) ? now_reg + 32'd1 : now_reg;
            tok0_next.found    = 1'b0;
            tok0_next.slot     = '0;
            tok0_next.was      = 1'b0;
            tok0_next.fire_cnt = '0;
            if (s_data.func == FUNC_TICK) begin
                now_next = now_reg + 32'd1;
            end
        end else if (!stall) begin
            tok0_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            now_reg        <= '0;
            tok0_reg.valid <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            now_reg        <= now_next;
            tok0_reg       <= tok0_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_slot_reg <= hold_slot_next;
        m_data_reg    <= m_data_next;
    end

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vld))
        else $error("more than one operation token in the cell row");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tok_vld == '0))
        else $error("input ready while a token is in flight");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> busy_reg)
        else $error("staged fired result outside of a tick");

    a_fire_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_any |-> (busy_reg && !end_tok.valid))
        else $error("fire request without a tick in the cell row");

endmodule

/* rtl/msot_cell.sv */
`timescale 1ns / 1ps

module msot_cell #(
    parameter int IDX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           stall,
    input  msot_pkg::tok_t tok_in,
    output msot_pkg::tok_t tok_out,
    output msot_pkg::fire_t fire
);
    import msot_pkg::*;

    localparam bit              IN_RANGE = (IDX < SEL_SPAN);
    localparam logic [ID_W-1:0] ID       = ID_W'(IDX);

    logic        active_reg;
    logic        active_next;
    logic [31:0] deadline_reg;
    logic [31:0] deadline_next;
    logic [23:0] interval_reg;
    logic [23:0] interval_next;
    tok_t        tok_reg;
    tok_t        tok_next;

    logic [31:0] diff;
    logic        due;
    logic        claim;
    logic        hit;
    logic        is_arm;

    assign diff   = tok_in.now - deadline_reg;
    assign is_arm = (tok_in.func == FUNC_ARM_ONE) || (tok_in.func == FUNC_ARM_PER);
    assign due    = tok_in.valid && (tok_in.func == FUNC_TICK) && active_reg && !diff[31]
                    && (tok_in.fire_cnt < MAX_FIRES);
    assign claim  = tok_in.valid && is_arm && !tok_in.found && !active_reg;
    assign hit    = tok_in.valid && (tok_in.func == FUNC_CANCEL) && IN_RANGE
                    && (tok_in.sel == ID);

    assign fire.req  = due;
    assign fire.slot = ID;
    assign tok_out   = tok_reg;

    always_comb begin
        tok_next      = tok_in;
        active_next   = active_reg;
        deadline_next = deadline_reg;
        interval_next = interval_reg;
        if (claim) begin
            tok_next.found = 1'b1;
            tok_next.slot  = ID;
            active_next    = 1'b1;
            deadline_next  = tok_in.now + {8'd0, tok_in.delay};
            interval_next  = (tok_in.func == FUNC_ARM_PER) ? tok_in.delay : 24'd0;
        end
        if (hit) begin
            tok_next.was = active_reg;
            active_next  = 1'b0;
        end
        if (due) begin
            tok_next.fire_cnt = tok_in.fire_cnt + 1'b1;
            if (interval_reg != 24'd0) begin
                deadline_next = tok_in.now + {8'd0, interval_reg};
            end else begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (!stall) begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            deadline_reg <= deadline_next;
            interval_reg <= interval_next;
        end
    end

endmodule
